>>> sv/assert_macros.svh
// assertion macros used by the checker module
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication into the next cycle, off during reset
`define ASSERT_NEXT(label, ante, cons, clk, rst_n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// invariant checked at every edge out of reset
`define ASSERT_ALWAYS(label, expr, clk, rst_n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`endif

>>> sv/xsr_pkg.sv
// shared constants and state type of the bounded xoshiro256** generator
// no dependencies
package xsr_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned NumWords = 4;
  localparam int unsigned CntW = $clog2(WordW);
  localparam int unsigned WordIdxW = $clog2(NumWords);

  localparam logic [WordW-1:0] GoldenStep = 64'h9e3779b97f4a7c15;
  localparam logic [WordW-1:0] MixMulA = 64'hbf58476d1ce4e5b9;
  localparam logic [WordW-1:0] MixMulB = 64'h94d049bb133111eb;
  localparam int unsigned XsShift = 17;
  localparam int unsigned XsRot = 45;

  typedef enum logic [3:0] {
    ST_SEED_ADD,
    ST_MUL_A,
    ST_XOR27,
    ST_MUL_B,
    ST_XOR31,
    ST_IDLE,
    ST_LIMIT,
    ST_DRAW,
    ST_MUL9,
    ST_CMP,
    ST_MOD,
    ST_OUT
  } state_e;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int unsigned r);
    return (v << r) | (v >> (WordW - r));
  endfunction

endpackage

>>> sv/xoshiro256ss_bounded_rng.sv
// xoshiro256** generator with unbiased bounded draws and splitmix64 seeding
// depends on xsr_pkg and xsr_div
// bound 0: the draw is taken whole, with no division; bound != 0: two passes of the
//   bit-serial remainder unit (limit, then remainder), plus a redraw per rejection
// one item at a time; a transfer is taken once the result is in the output register
// reset and each seed write run a seeding pass, no transfer taken meanwhile
module xoshiro256ss_bounded_rng import xsr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [WordW-1:0] bound_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WordW-1:0] value_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [WordW-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [WordW-1:0]    acc_q;
  logic [WordIdxW-1:0] word_q;
  logic [CntW-1:0]     cnt_q;
  logic [WordW-1:0]    z_q, p_q, k_q;
  logic [WordW-1:0]    gen_q [NumWords];
  logic [WordW-1:0]    bound_q, limit_q, mul5_q, v_q, res_q;
  logic                out_valid_q;
  logic [WordW-1:0]    value_q;

  logic             in_xfer, cfg_xfer, out_free, out_load;
  logic             div_start, div_done;
  logic [WordW-1:0] div_num, div_den, div_rem;
  logic [WordW-1:0] acc_next, mix27, mix31, rot5;

  assign in_xfer = in_valid_i && !in_stall_o;
  assign cfg_xfer = cfg_valid_i && cfg_ready_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign acc_next = acc_q + GoldenStep;
  assign mix27 = p_q ^ (p_q >> 27);
  assign mix31 = p_q ^ (p_q >> 31);
  assign rot5 = rotl(mul5_q, 7);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SEED_ADD: state_d = ST_MUL_A;
      ST_MUL_A:    if (cnt_q == CntW'(WordW - 1)) state_d = ST_XOR27;
      ST_XOR27:    state_d = ST_MUL_B;
      ST_MUL_B:    if (cnt_q == CntW'(WordW - 1)) state_d = ST_XOR31;
      ST_XOR31: begin
        state_d = (word_q == WordIdxW'(NumWords - 1)) ? ST_IDLE : ST_SEED_ADD;
      end
      ST_IDLE: begin
        priority if (cfg_xfer) begin
          state_d = ST_SEED_ADD;
        end else if (in_xfer) begin
          state_d = (bound_i == '0) ? ST_DRAW : ST_LIMIT;
        end
      end
      ST_LIMIT:    if (div_done) state_d = ST_DRAW;
      ST_DRAW:     state_d = ST_MUL9;
      ST_MUL9:     state_d = ST_CMP;
      ST_CMP: begin
        priority if (bound_q == '0) begin
          state_d = ST_OUT;
        end else if (v_q < limit_q) begin
          state_d = ST_DRAW;
        end else begin
          state_d = ST_MOD;
        end
      end
      ST_MOD:      if (div_done) state_d = ST_OUT;
      ST_OUT:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE) || cfg_valid_i;
    cfg_ready_o = (state_q == ST_IDLE);
    out_load = (state_q == ST_OUT) && out_free;
    div_start = 1'b0;
    div_num = v_q;
    div_den = bound_q;
    unique case (state_q)
      ST_IDLE: begin
        div_start = in_xfer && (bound_i != '0);
        div_num = '0 - bound_i;
        div_den = bound_i;
      end
      ST_CMP:  div_start = (bound_q != '0) && !(v_q < limit_q);
      default: div_start = 1'b0;
    endcase
  end

  xsr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SEED_ADD;
      acc_q <= '0;
      word_q <= '0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_xfer) begin
        acc_q <= cfg_data_i;
        word_q <= '0;
      end
      unique case (state_q)
        ST_SEED_ADD: begin
          acc_q <= acc_next;
          cnt_q <= '0;
        end
        ST_MUL_A, ST_MUL_B: cnt_q <= cnt_q + 1'b1;
        ST_XOR27: cnt_q <= '0;
        ST_XOR31: word_q <= word_q + 1'b1;
        default: cnt_q <= cnt_q;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_SEED_ADD: begin
        z_q <= acc_next ^ (acc_next >> 30);
        p_q <= '0;
        k_q <= MixMulA;
      end
      ST_MUL_A, ST_MUL_B: begin
        // shift-add multiply, one multiplier bit per cycle
        p_q <= p_q + (k_q[0] ? z_q : '0);
        z_q <= z_q << 1;
        k_q <= k_q >> 1;
      end
      ST_XOR27: begin
        z_q <= mix27;
        p_q <= '0;
        k_q <= MixMulB;
      end
      ST_XOR31: begin
        gen_q[0] <= gen_q[1];
        gen_q[1] <= gen_q[2];
        gen_q[2] <= gen_q[3];
        gen_q[3] <= mix31;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          bound_q <= bound_i;
          limit_q <= '0;
        end
      end
      ST_LIMIT: if (div_done) limit_q <= div_rem;
      ST_DRAW: begin
        mul5_q <= gen_q[1] + (gen_q[1] << 2);
        gen_q[0] <= gen_q[0] ^ gen_q[3] ^ gen_q[1];
        gen_q[1] <= gen_q[1] ^ gen_q[2] ^ gen_q[0];
        gen_q[2] <= gen_q[2] ^ gen_q[0] ^ (gen_q[1] << XsShift);
        gen_q[3] <= rotl(gen_q[3] ^ gen_q[1], XsRot);
      end
      ST_MUL9: v_q <= rot5 + (rot5 << 3);
      ST_CMP:  if (bound_q == '0) res_q <= v_q;
      ST_MOD:  if (div_done) res_q <= div_rem;
      ST_OUT:  if (out_free) value_q <= res_q;
      default: res_q <= res_q;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign value_o = value_q;

endmodule

>>> sv/xsr_div.sv
// bit-serial restoring remainder unit, one quotient bit per cycle
// depends on xsr_pkg
module xsr_div import xsr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WordW-1:0] dividend_i,
  input  logic [WordW-1:0] divisor_i,
  output logic             done_o,
  output logic [WordW-1:0] rem_o
);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [WordW:0]  rem_q, rem_d;
  logic [WordW-1:0] num_q, num_d;
  logic [WordW-1:0] den_q, den_d;
  logic [WordW:0]  rem_sh;
  logic [WordW+1:0] diff;

  always_comb begin
    rem_sh = {rem_q[WordW-1:0], num_q[WordW-1]};
    diff = {1'b0, rem_sh} - {2'b00, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    rem_d = rem_q;
    num_d = num_q;
    den_d = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      num_d = dividend_i;
      den_d = divisor_i;
    end else if (busy_q) begin
      num_d = num_q << 1;
      rem_d = diff[WordW+1] ? rem_sh : diff[WordW:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign rem_o = rem_q[WordW-1:0];

endmodule

>>> sv/xsr_chk.sv
// port-level checker for the bounded xoshiro256** generator, with its bind
// depends on xsr_pkg and assert_macros.svh
`include "assert_macros.svh"

module xsr_chk import xsr_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [WordW-1:0] value_o,
  input logic             cfg_valid_i,
  input logic             cfg_ready_o
);

  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(value_o), clk_i, rst_ni)
  `ASSERT_NEXT(a_busy_after_in, in_valid_i && !in_stall_o, in_stall_o && !cfg_ready_o, clk_i, rst_ni)
  `ASSERT_NEXT(a_seed_blocks, cfg_valid_i && cfg_ready_o, in_stall_o && !cfg_ready_o, clk_i, rst_ni)
  `ASSERT_ALWAYS(a_open_idle, in_stall_o || cfg_ready_o, clk_i, rst_ni)

endmodule

bind xoshiro256ss_bounded_rng xsr_chk u_chk (.*);
